/* src/ssbd_pkg.sv */
// Shared types and constants for the source step break detector.
package ssbd_pkg;

    localparam int MAP_DEPTH = 256;
    localparam int ADDR_W    = $clog2(MAP_DEPTH);
    localparam int CNT_W     = ADDR_W + 1;
    localparam int CFG_W     = 17;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FROM_LINE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FROM_FILE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OVER_DEPTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_DEPTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_COUNT  = 3'd5;

    localparam logic [1:0] MODE_NONE = 2'd0;
    localparam logic [1:0] MODE_INTO = 2'd1;
    localparam logic [1:0] MODE_OVER = 2'd2;
    localparam logic [1:0] MODE_OUT  = 2'd3;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [15:0] instr;
        logic [15:0] line;
        logic [7:0]  file;
    } map_entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } state_t;

endpackage

/* src/ssbd_if.sv */
// Item channel interfaces for the source step break detector.
interface ssbd_in_if;
    logic        valid;
    logic        ready;
    logic        op;
    logic [7:0]  entry_slot;
    logic [15:0] entry_instr;
    logic [15:0] entry_line;
    logic [7:0]  entry_file;
    logic [15:0] query_instr;
    logic [9:0]  call_depth;

    modport source (output valid, op, entry_slot, entry_instr, entry_line, entry_file,
                    query_instr, call_depth, input ready);
    modport sink (input valid, op, entry_slot, entry_instr, entry_line, entry_file,
                  query_instr, call_depth, output ready);
endinterface

interface ssbd_out_if;
    logic               valid;
    logic               ready;
    logic               stop_now;
    logic               located;
    logic signed [16:0] found_line;
    logic signed [8:0]  found_file;

    modport source (output valid, stop_now, located, found_line, found_file, input ready);
    modport sink (input valid, stop_now, located, found_line, found_file, output ready);
endinterface

/* src/source_step_break_detector_core.sv */
// Source step break detector: map table, sequential scan and stop decision.
// Load item: accepted in the idle state, no result; loads are taken while an issued result waits.
// Query item, n = min(map_count, MAP_DEPTH): the first n map entries are scanned, then
//   the result state issues the result; input ready returns together with the result valid.
// A result not taken holds the block in the result state until the output frees.
// Reset clears control and configuration; map contents stay undefined until loaded.
module source_step_break_detector_core (
    input  logic                              clk,
    input  logic                              rst_n,
    ssbd_in_if.sink                           in_ch,
    ssbd_out_if.source                        out_ch,
    input  logic                              cfg_we,
    input  logic [ssbd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ssbd_pkg::CFG_W-1:0]        cfg_data
);

    ssbd_pkg::state_t state_reg, state_next;

    logic [1:0]               step_mode_reg;
    logic signed [16:0]       from_line_reg;
    logic signed [8:0]        from_file_reg;
    logic signed [10:0]       over_depth_reg;
    logic signed [10:0]       out_depth_reg;
    logic [8:0]               map_count_reg;

    logic [ssbd_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic [ssbd_pkg::CNT_W-1:0] n_reg, n_next;
    logic [15:0]              q_reg, q_next;
    logic [9:0]               depth_reg, depth_next;
    logic                     rd_pend_reg, rd_pend_next;
    logic                     hit_reg, hit_next;
    ssbd_pkg::map_entry_t     best_reg, best_next;

    logic                     out_valid_reg, out_valid_next;
    logic                     stop_reg, stop_next;
    logic                     located_reg, located_next;
    logic signed [16:0]       line_reg, line_next;
    logic signed [8:0]        file_reg, file_next;

    ssbd_pkg::map_entry_t     map_mem [ssbd_pkg::MAP_DEPTH];
    ssbd_pkg::map_entry_t     rd_data_reg;
    logic                     mem_we;
    logic [ssbd_pkg::ADDR_W-1:0] mem_wr_addr;
    ssbd_pkg::map_entry_t     mem_wr_data;

    logic                     in_acc;
    logic                     issue;
    logic [ssbd_pkg::CNT_W-1:0] cnt_cap;
    logic signed [16:0]       res_line;
    logic signed [8:0]        res_file;
    logic                     moved;
    logic signed [10:0]       depth_s;
    logic                     stop_calc;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_mode_reg  <= ssbd_pkg::MODE_NONE;
            from_line_reg  <= '1;
            from_file_reg  <= '1;
            over_depth_reg <= '1;
            out_depth_reg  <= '1;
            map_count_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ssbd_pkg::CFG_STEP_MODE:  step_mode_reg  <= cfg_data[1:0];
                ssbd_pkg::CFG_FROM_LINE:  from_line_reg  <= cfg_data[16:0];
                ssbd_pkg::CFG_FROM_FILE:  from_file_reg  <= cfg_data[8:0];
                ssbd_pkg::CFG_OVER_DEPTH: over_depth_reg <= cfg_data[10:0];
                ssbd_pkg::CFG_OUT_DEPTH:  out_depth_reg  <= cfg_data[10:0];
                ssbd_pkg::CFG_MAP_COUNT:  map_count_reg  <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // map memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_wr_addr] <= mem_wr_data;
        end
        rd_data_reg <= map_mem[idx_reg[ssbd_pkg::ADDR_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssbd_pkg::ST_IDLE;
            idx_reg       <= '0;
            n_reg         <= '0;
            rd_pend_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            rd_pend_reg   <= rd_pend_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg       <= q_next;
        depth_reg   <= depth_next;
        best_reg    <= best_next;
        stop_reg    <= stop_next;
        located_reg <= located_next;
        line_reg    <= line_next;
        file_reg    <= file_next;
    end

    // result fields and stop rule
    always_comb
    begin
        res_line  = hit_reg ? {1'b0, best_reg.line} : '1;
        res_file  = hit_reg ? {1'b0, best_reg.file} : '1;
        moved     = (res_line != from_line_reg) || (res_file != from_file_reg);
        depth_s   = {1'b0, depth_reg};
        stop_calc = 1'b0;
        if (step_mode_reg != ssbd_pkg::MODE_NONE && hit_reg)
        begin
            if (from_line_reg == '1)
            begin
                stop_calc = 1'b1;
            end
            else
            begin
                unique case (step_mode_reg)
                    ssbd_pkg::MODE_INTO: stop_calc = moved;
                    ssbd_pkg::MODE_OVER: stop_calc = moved && (depth_s <= over_depth_reg);
                    ssbd_pkg::MODE_OUT:  stop_calc = depth_s < out_depth_reg;
                    default:             stop_calc = 1'b0;
                endcase
            end
        end
    end

    assign cnt_cap = (map_count_reg > ssbd_pkg::CNT_W'(ssbd_pkg::MAP_DEPTH))
                   ? ssbd_pkg::CNT_W'(ssbd_pkg::MAP_DEPTH) : map_count_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        q_next         = q_reg;
        depth_next     = depth_reg;
        rd_pend_next   = rd_pend_reg;
        hit_next       = hit_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg;
        stop_next      = stop_reg;
        located_next   = located_reg;
        line_next      = line_reg;
        file_next      = file_reg;
        issue          = 1'b0;

        in_ch.ready    = (state_reg == ssbd_pkg::ST_IDLE);
        in_acc         = in_ch.valid && in_ch.ready;
        mem_we         = in_acc && (in_ch.op == ssbd_pkg::OP_LOAD)
                      && ({1'b0, in_ch.entry_slot} < 9'(ssbd_pkg::MAP_DEPTH));
        mem_wr_addr    = in_ch.entry_slot[ssbd_pkg::ADDR_W-1:0];
        mem_wr_data    = '{instr: in_ch.entry_instr, line: in_ch.entry_line,
                           file: in_ch.entry_file};

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ssbd_pkg::ST_IDLE:
            begin
                if (in_acc && in_ch.op == ssbd_pkg::OP_QUERY)
                begin
                    q_next       = in_ch.query_instr;
                    depth_next   = in_ch.call_depth;
                    n_next       = cnt_cap;
                    idx_next     = '0;
                    rd_pend_next = 1'b0;
                    hit_next     = 1'b0;
                    state_next   = ssbd_pkg::ST_SCAN;
                end
            end
            ssbd_pkg::ST_SCAN:
            begin
                issue        = idx_reg < n_reg;
                rd_pend_next = issue;
                if (issue)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                if (rd_pend_reg && rd_data_reg.instr <= q_reg
                    && (!hit_reg || rd_data_reg.instr > best_reg.instr))
                begin
                    hit_next  = 1'b1;
                    best_next = rd_data_reg;
                end
                if (!issue && !rd_pend_reg)
                begin
                    state_next = ssbd_pkg::ST_RESULT;
                end
            end
            ssbd_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    stop_next      = stop_calc;
                    located_next   = hit_reg;
                    line_next      = res_line;
                    file_next      = res_file;
                    state_next     = ssbd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssbd_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_ch.valid      = out_valid_reg;
    assign out_ch.stop_now   = stop_reg;
    assign out_ch.located    = located_reg;
    assign out_ch.found_line = line_reg;
    assign out_ch.found_file = file_reg;

    a_unlocated_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !located_reg)
        |-> (line_reg == '1 && file_reg == '1 && !stop_reg))
        else $error("unlocated result carries entry data or a stop");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssbd_pkg::ST_SCAN)
        |-> (idx_reg <= n_reg && n_reg <= ssbd_pkg::CNT_W'(ssbd_pkg::MAP_DEPTH)))
        else $error("scan index beyond entry count");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ssbd_pkg::ST_RESULT))
        else $error("result issued outside result state");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ssbd_pkg::ST_SCAN) |=> (state_reg != ssbd_pkg::ST_IDLE))
        else $error("scan skipped result state");

endmodule
